/* rtl/core/sfd_pkg.sv */
package sfd_pkg;
	localparam int unsigned QBITS = 26;
	localparam logic [31:0] ZERO_BY_ZERO = 32'h7f880000;
	localparam logic [7:0] EXP_ALL_ONES = 8'hff;
	localparam logic [9:0] EXP_BIAS = 10'd127;

	// Side information that rides with the remainder through the cell row
	typedef struct packed {
		logic        sign;
		logic [9:0]  exp;
		logic        a_zero;
		logic        b_zero;
	} side_t;

	// Payload handed from one cell to the next
	typedef struct packed {
		logic        vld;
		logic [24:0] rem;
		logic [23:0] den;
		logic [25:0] quo;
		side_t       side;
	} link_t;
endpackage

/* rtl/core/single_float_divide.sv */
// single_float_divide: IEEE single precision divide, dividend / divisor.
// Input transaction on s_axis: tdata = {divisor, dividend}. Output
// transaction on m_axis: tdata = quotient, tuser = {overflow, negative, zero}.
// The significands go through a row of 26 restoring cells, one quotient
// bit per cell, then a registered normalize/round stage. The row advances as a
// whole and holds only one item, so a new input is not accepted until
// the previous result has been taken.
// Denormal, NaN and infinity inputs are treated as ordinary numbers.
// Reset clears all valid bits; the block is empty after reset.
// When the receiver stalls, the result holds in the output register and
// no new input is accepted until it is taken.
module single_float_divide (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [63:0] s_axis_tdata,  // [31:0] dividend, [63:32] divisor
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata,  // [31:0] quotient
	output logic [2:0]  m_axis_tuser   // [0] zero, [1] negative, [2] overflow
);
	localparam int unsigned N = sfd_pkg::QBITS;

	sfd_pkg::link_t lnk [0:N];
	logic busy_q;
	logic acc;
	logic [31:0] a, b;
	logic [9:0] e0, e1, e2;
	logic [24:0] mant;
	logic [23:0] mnt;
	logic [31:0] q_c;
	logic z_c, o_c;
	logic sgn;
	sfd_pkg::link_t last;

	assign a = s_axis_tdata[31:0];
	assign b = s_axis_tdata[63:32];
	assign s_axis_tready = ~busy_q;
	assign acc = s_axis_tvalid & s_axis_tready;

	// Feed the first cell
	always_comb begin
		lnk[0].vld = acc;
		lnk[0].rem = {1'b0, 1'b1, a[22:0]};
		lnk[0].den = {1'b1, b[22:0]};
		lnk[0].quo = '0;
		lnk[0].side.sign = a[31] ^ b[31];
		lnk[0].side.exp = {2'b00, a[30:23]} - {2'b00, b[30:23]} + sfd_pkg::EXP_BIAS;
		lnk[0].side.a_zero = (a[30:0] == 31'd0);
		lnk[0].side.b_zero = (b[30:0] == 31'd0);
	end

	genvar g;
	generate
		for (g = 0; g < N; g++) begin : g_cell
			sfd_cell u_cell (
				.clk(clk), .arst_n(arst_n), .adv(1'b1),
				.din(lnk[g]), .dout(lnk[g+1])
			);
		end
	endgenerate

	assign last = lnk[N];

	// Normalize and round half up
	always_comb begin
		sgn = last.side.sign;
		e0 = last.side.exp;
		if (last.quo[25]) begin
			mant = {1'b0, last.quo[25:2]} + {24'd0, last.quo[1]};
			e1 = e0;
		end else begin
			mant = {1'b0, last.quo[24:1]} + {24'd0, last.quo[0]};
			e1 = e0 - 10'd1;
		end
		if (mant[24]) begin
			mnt = mant[24:1];
			e2 = e1 + 10'd1;
		end else begin
			mnt = mant[23:0];
			e2 = e1;
		end
		z_c = 1'b0;
		o_c = 1'b0;
		priority if (last.side.a_zero && last.side.b_zero) begin
			q_c = sfd_pkg::ZERO_BY_ZERO;
			o_c = 1'b1;
		end else if (last.side.b_zero) begin
			q_c = {sgn, sfd_pkg::EXP_ALL_ONES, 23'd0};
			o_c = 1'b1;
		end else if (last.side.a_zero) begin
			q_c = {sgn, 31'd0};
			z_c = 1'b1;
		end else if (!e2[9] && e2 >= 10'd255) begin
			q_c = {sgn, sfd_pkg::EXP_ALL_ONES, 23'd0};
			o_c = 1'b1;
		end else if (e2[9] || e2 == 10'd0) begin
			q_c = {sgn, 31'd0};
			z_c = 1'b1;
			o_c = 1'b1;
		end else begin
			q_c = {sgn, e2[7:0], mnt[22:0]};
		end
	end

	// Busy from acceptance until the result is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			m_axis_tvalid <= 1'b0;
		end else begin
			if (acc) busy_q <= 1'b1;
			else if (m_axis_tvalid && m_axis_tready) busy_q <= 1'b0;
			if (last.vld) m_axis_tvalid <= 1'b1;
			else if (m_axis_tready) m_axis_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last.vld) begin
			m_axis_tdata <= q_c;
			m_axis_tuser <= {o_c, q_c[31], z_c};
		end
	end
endmodule

/* rtl/core/sfd_cell.sv */
module sfd_cell (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           adv,
	input  sfd_pkg::link_t din,
	output sfd_pkg::link_t dout
);
	logic [25:0] diff;
	logic        take;
	sfd_pkg::link_t link_q;

	// One restoring step: compare, subtract, shift
	assign diff = {1'b0, din.rem} - {2'b00, din.den};
	assign take = ~diff[25];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_q <= '0;
		end else if (adv) begin
			link_q.vld  <= din.vld;
			link_q.rem  <= take ? {diff[23:0], 1'b0} : {din.rem[23:0], 1'b0};
			link_q.den  <= din.den;
			link_q.quo  <= {din.quo[24:0], take};
			link_q.side <= din.side;
		end
	end

	assign dout = link_q;
endmodule

/* rtl/core/sfd_checker.sv */
module sfd_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [31:0] m_axis_tdata,
	input logic [2:0]  m_axis_tuser
);
	// Negative flag mirrors the sign bit
	a_neg: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> m_axis_tuser[1] == m_axis_tdata[31])
		else $error("negative flag mismatch");
	// No input taken while a result waits
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready)
		else $error("input ready while output valid");
	// Result held while stalled
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
		else $error("stalled result changed");
	// Zero flag means zero magnitude
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |-> m_axis_tdata[30:0] == 31'd0)
		else $error("zero flag on nonzero result");
endmodule

bind single_float_divide sfd_checker u_sfd_checker (
	.clk(clk), .arst_n(arst_n),
	.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
	.m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
